// ===== sv/mcbf_pkg.sv =====
// Shared types, constants and codes of the match candidate probability fusion block.
package mcbf_pkg;

  localparam int PROB_BITS          = 24;
  localparam int MIN_FREQ_W         = 23;
  localparam int CONF_W             = 16;
  localparam int WEIGHT_W           = CONF_W + 1;
  localparam int NUM_CANDIDATES_DEF = 4;
  localparam int APB_DATA_W         = 32;
  localparam int APB_ADDR_W         = 3;

  localparam logic [PROB_BITS:0]   PROB_SCALE = (PROB_BITS + 1)'(1) << PROB_BITS;
  localparam logic [PROB_BITS-1:0] PROB_HALF  = PROB_BITS'(1) << (PROB_BITS - 1);
  localparam logic [CONF_W-1:0]    SAT_MAX    = '1;

  // register index, taken from paddr[2]
  localparam logic REG_MIN_BIT_FREQ = 1'b0;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              present;
    logic [7:0]        pred_byte;
    logic [CONF_W-1:0] conf;
    logic [CONF_W-1:0] len;
  } cand_t;

  typedef struct packed {
    logic       en;
    logic [1:0] slot;
    cand_t      cand;
  } cand_load_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FUSE,
    ST_CLAMP
  } state_t;

endpackage

// ===== sv/match_candidate_bit_probability_fusion.sv =====
// Top level: command interface, config register, sequencer and fusion datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------------
//  request   | start, busy          | req_type slot present pred_byte confidence
//            |                      | match_len prefix_len prefix_bits model_p1 second_p1
//  result    | done (one-cycle)     | fused_p1 match_active match_p1 error
//  config    | psel penable pwrite  | paddr pwdata prdata pready
//
// A load or a rejected query returns its result in the cycle after the beat; busy stays low.
// A valid query holds busy through one scan step per candidate, then, when a candidate
// agrees, the serial divider at one quotient bit per cycle, then fuse and clamp.
// The result follows on the cycle busy falls. rst clears the table's present bits at once.
// The result side cannot stall; done marks each result for exactly one cycle.
module match_candidate_bit_probability_fusion #(
  parameter int NUM_CANDIDATES = mcbf_pkg::NUM_CANDIDATES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type,
  input  logic [1:0]                           slot,
  input  logic                                 present,
  input  logic [7:0]                           pred_byte,
  input  logic [31:0]                          confidence,
  input  logic [31:0]                          match_len,
  input  logic [2:0]                           prefix_len,
  input  logic [6:0]                           prefix_bits,
  input  logic [mcbf_pkg::PROB_BITS-1:0]       model_p1,
  input  logic [mcbf_pkg::PROB_BITS-1:0]       second_p1,
  output logic                                 done,
  output logic [mcbf_pkg::PROB_BITS-1:0]       fused_p1,
  output logic                                 match_active,
  output logic [mcbf_pkg::PROB_BITS-1:0]       match_p1,
  output logic                                 error,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcbf_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mcbf_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mcbf_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int PB    = mcbf_pkg::PROB_BITS;
  localparam int IDX_W = (NUM_CANDIDATES > 1) ? $clog2(NUM_CANDIDATES) : 1;
  localparam int ACC_W = mcbf_pkg::WEIGHT_W + 1 + IDX_W;

  mcbf_pkg::state_t state, state_next;

  logic [mcbf_pkg::MIN_FREQ_W-1:0] min_bit_freq;

  logic [PB-1:0] mp;
  logic [PB-1:0] sp;
  logic [PB-1:0] match_p;
  logic          active;
  logic [PB-1:0] fused_raw;

  logic accept;
  logic is_load;
  logic req_ok;
  logic scan_start;
  logic scan_done;
  logic div_start;
  logic div_done;

  logic [ACC_W-1:0] w0;
  logic [ACC_W-1:0] w1;
  logic [ACC_W-1:0] total;
  logic [ACC_W-1:0] div_num;
  logic [ACC_W-1:0] div_den;
  logic [PB-1:0]    quo;

  mcbf_pkg::cand_load_t load;

  logic [PB+1:0] weighted;
  logic [PB+1:0] rounded;
  logic [PB:0]   lo;
  logic [PB:0]   hi;
  logic [PB:0]   lo_clamped;
  logic [PB:0]   clamped;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_bit_freq <= mcbf_pkg::MIN_FREQ_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == mcbf_pkg::REG_MIN_BIT_FREQ)) begin
      min_bit_freq <= pwdata[mcbf_pkg::MIN_FREQ_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mcbf_pkg::REG_MIN_BIT_FREQ) begin
      prdata = mcbf_pkg::APB_DATA_W'(min_bit_freq);
    end
  end

  // request decode
  assign busy    = state != mcbf_pkg::ST_IDLE;
  assign accept  = start && !busy;
  assign is_load = req_type == mcbf_pkg::REQ_LOAD;
  assign req_ok  = ((prefix_bits >> prefix_len) == 7'd0) &&
                   (model_p1 != '0) && (second_p1 != '0);

  assign load.en                = accept && is_load;
  assign load.slot              = slot;
  assign load.cand.present      = present;
  assign load.cand.pred_byte    = pred_byte;
  assign load.cand.conf         = (confidence[31:16] != '0) ? mcbf_pkg::SAT_MAX
                                                            : confidence[15:0];
  assign load.cand.len          = (match_len[31:16] != '0) ? mcbf_pkg::SAT_MAX
                                                           : match_len[15:0];

  mcbf_cand_table #(
    .NUM_CANDIDATES (NUM_CANDIDATES),
    .ACC_W          (ACC_W)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .scan_start  (scan_start),
    .prefix_len  (prefix_len),
    .prefix_bits (prefix_bits),
    .scan_done   (scan_done),
    .w0          (w0),
    .w1          (w1)
  );

  assign total   = w0 + w1;
  assign div_num = w1 + ACC_W'(1);
  assign div_den = total + ACC_W'(2);

  mcbf_div #(
    .DEN_W (ACC_W),
    .Q_W   (PB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      mcbf_pkg::ST_IDLE: begin
        if (accept && !is_load && req_ok) begin
          scan_start = 1'b1;
          state_next = mcbf_pkg::ST_SCAN;
        end
      end
      mcbf_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (total != '0) begin
            div_start  = 1'b1;
            state_next = mcbf_pkg::ST_DIV;
          end else begin
            state_next = mcbf_pkg::ST_FUSE;
          end
        end
      end
      mcbf_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = mcbf_pkg::ST_FUSE;
        end
      end
      mcbf_pkg::ST_FUSE: begin
        state_next = mcbf_pkg::ST_CLAMP;
      end
      mcbf_pkg::ST_CLAMP: begin
        state_next = mcbf_pkg::ST_IDLE;
      end
      default: begin
        state_next = mcbf_pkg::ST_IDLE;
      end
    endcase
  end

  // fusion datapath: 2:1:1 with the match side, 3:1 without
  assign weighted = active ? ((PB + 2)'(mp) << 1) + (PB + 2)'(sp) + (PB + 2)'(match_p)
                           : ((PB + 2)'(mp) << 1) + (PB + 2)'(mp) + (PB + 2)'(sp);
  assign rounded  = (weighted + (PB + 2)'(2)) >> 2;

  // lower bound first, upper bound wins when they cross
  assign lo         = (PB + 1)'(min_bit_freq);
  assign hi         = (lo <= mcbf_pkg::PROB_SCALE) ? mcbf_pkg::PROB_SCALE - lo : '0;
  assign lo_clamped = ({1'b0, fused_raw} < lo) ? lo : {1'b0, fused_raw};
  assign clamped    = (lo_clamped > hi) ? hi : lo_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (is_load || !req_ok)) || (state == mcbf_pkg::ST_CLAMP);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mp <= model_p1;
      sp <= second_p1;
      if (is_load || !req_ok) begin
        fused_p1     <= '0;
        match_active <= 1'b0;
        match_p1     <= '0;
        error        <= !is_load;
      end
    end
    if (state == mcbf_pkg::ST_SCAN && scan_done) begin
      active  <= total != '0;
      match_p <= mcbf_pkg::PROB_HALF;
    end
    if (state == mcbf_pkg::ST_DIV && div_done) begin
      match_p <= (quo == '0) ? PB'(1) : quo;
    end
    if (state == mcbf_pkg::ST_FUSE) begin
      fused_raw <= rounded[PB-1:0];
    end
    if (state == mcbf_pkg::ST_CLAMP) begin
      fused_p1     <= clamped[PB-1:0];
      match_active <= active;
      match_p1     <= match_p;
      error        <= 1'b0;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a query is in flight");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat produced neither work nor a result");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("query finished without a result");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> ((fused_p1 == '0) && !match_active && (match_p1 == '0)))
    else $error("error result carries a nonzero payload");

endmodule

// ===== sv/mcbf_cand_table.sv =====
// Candidate table with a serial scan that sums agreeing weights per next bit.
module mcbf_cand_table #(
  parameter int NUM_CANDIDATES = mcbf_pkg::NUM_CANDIDATES_DEF,
  parameter int ACC_W          = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcbf_pkg::cand_load_t load,
  input  logic                 scan_start,
  input  logic [2:0]           prefix_len,
  input  logic [6:0]           prefix_bits,
  output logic                 scan_done,
  output logic [ACC_W-1:0]     w0,
  output logic [ACC_W-1:0]     w1
);

  localparam int IDX_W = (NUM_CANDIDATES > 1) ? $clog2(NUM_CANDIDATES) : 1;

  mcbf_pkg::cand_t tbl [NUM_CANDIDATES];

  logic [IDX_W-1:0] idx;
  logic             running;
  logic [2:0]       plen;
  logic [6:0]       pbits;

  logic [2:0]                      slot_ext;
  logic                            slot_ok;
  mcbf_pkg::cand_t                 cur;
  logic                            hit;
  logic                            nbit;
  logic [mcbf_pkg::WEIGHT_W-1:0]   weight;
  logic                            last;

  assign slot_ext = {1'b0, load.slot};
  assign slot_ok  = {1'b0, slot_ext} < 4'(NUM_CANDIDATES);

  assign cur    = tbl[idx];
  assign hit    = cur.present &&
                  ((plen == 3'd0) ||
                   ((cur.pred_byte >> (4'd8 - {1'b0, plen})) == {1'b0, pbits}));
  assign nbit   = cur.pred_byte[3'd7 - plen];
  assign weight = mcbf_pkg::WEIGHT_W'(cur.conf) + mcbf_pkg::WEIGHT_W'(cur.len) +
                  mcbf_pkg::WEIGHT_W'(1);
  assign last   = idx == IDX_W'(NUM_CANDIDATES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CANDIDATES; i++) begin
        tbl[i].present <= 1'b0;
      end
    end else if (load.en && slot_ok) begin
      tbl[slot_ext[IDX_W-1:0]] <= load.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      scan_done <= 1'b0;
      idx       <= '0;
    end else begin
      scan_done <= running && last;
      if (scan_start) begin
        running <= 1'b1;
        idx     <= '0;
      end else if (running) begin
        if (last) begin
          running <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      w0    <= '0;
      w1    <= '0;
      plen  <= prefix_len;
      pbits <= prefix_bits;
    end else if (running && hit) begin
      if (nbit) begin
        w1 <= w1 + ACC_W'(weight);
      end else begin
        w0 <= w0 + ACC_W'(weight);
      end
    end
  end

endmodule

// ===== sv/mcbf_div.sv =====
// Restoring radix-2 divider: rounded num * 2^Q_W / den, one quotient bit a cycle.
module mcbf_div #(
  parameter int DEN_W = 20,
  parameter int Q_W   = mcbf_pkg::PROB_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [Q_W-1:0]   low;
  logic [CNT_W-1:0] cnt;
  logic             running;

  logic [DEN_W:0] trial;
  logic           ge;
  logic [DEN_W:0] diff;

  assign trial = {rem, low[Q_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(Q_W - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CNT_W'(Q_W - 1)) begin
          running <= 1'b0;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // dividend is num above the Q_W fraction bits, with den/2 in them for rounding
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
      low <= Q_W'(den >> 1);
    end else if (running) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low <= low << 1;
      quo <= {quo[Q_W-2:0], ge};
    end
  end

endmodule
